>>> hdl/lrukv_pkg.sv
package lrukv_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int CFG_W        = 5;
	localparam int KEY_W        = 32;
	localparam int VAL_W        = 32;
	localparam int IN_DATA_W    = KEY_W + VAL_W;
	localparam int OUT_USER_W   = 2;
	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_busy;
	} dp_status_t;

endpackage

>>> hdl/lru_key_value_cache.sv
// Each request is accepted in ST_IDLE, scans every slot in ST_SCAN through the
// single-read-port key memory, passes ST_DRAIN and writes its result to the output
// register in ST_COMMIT, which waits while an earlier result is not yet taken. The next
// request is taken while the previous result still waits in the output register.
// Reset (arst_n, asynchronous, active low): all entries invalid, ranks and count zero,
// capacity register 16, no result pending.
module lru_key_value_cache #(
	parameter int CAPACITY = lrukv_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lrukv_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lrukv_pkg::IN_DATA_W-1:0]     s_tdata,   // key[31:0], value[63:32]
	input  logic                                s_tuser,   // func
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lrukv_pkg::VAL_W-1:0]         m_tdata,   // data
	output logic [lrukv_pkg::OUT_USER_W-1:0]    m_tuser    // found[0], evicted[1]
);

	lrukv_pkg::ctrl_cmd_t  cmd;
	lrukv_pkg::dp_status_t status;

	lrukv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lrukv_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

>>> hdl/lrukv_ctrl.sv
module lrukv_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  lrukv_pkg::dp_status_t  status,
	output lrukv_pkg::ctrl_cmd_t   cmd
);

	lrukv_pkg::state_t state_q;
	lrukv_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrukv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrukv_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = lrukv_pkg::ST_SCAN;
				end
			end
			lrukv_pkg::ST_SCAN: begin
				if (status.scan_last) begin
					state_d = lrukv_pkg::ST_DRAIN;
				end
			end
			lrukv_pkg::ST_DRAIN: begin
				state_d = lrukv_pkg::ST_COMMIT;
			end
			lrukv_pkg::ST_COMMIT: begin
				if (!status.out_busy) begin
					state_d = lrukv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lrukv_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.start  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			lrukv_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.start = s_tvalid;
			end
			lrukv_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			lrukv_pkg::ST_DRAIN: begin
			end
			lrukv_pkg::ST_COMMIT: begin
				cmd.commit = !status.out_busy;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hdl/lrukv_dp.sv
module lrukv_dp #(
	parameter int CAPACITY = lrukv_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lrukv_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic [lrukv_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lrukv_pkg::VAL_W-1:0]         m_tdata,
	output logic [lrukv_pkg::OUT_USER_W-1:0]    m_tuser,
	input  lrukv_pkg::ctrl_cmd_t                cmd,
	output lrukv_pkg::dp_status_t               status
);

	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int EW     = (CNT_W > lrukv_pkg::CFG_W) ? CNT_W : lrukv_pkg::CFG_W;
	localparam int KW     = lrukv_pkg::KEY_W;
	localparam int VW     = lrukv_pkg::VAL_W;

	logic [KW-1:0] key_mem [CAPACITY];
	logic [VW-1:0] val_mem [CAPACITY];

	logic [CAPACITY-1:0]        valid_q;
	logic [RANK_W-1:0]          rank_q [CAPACITY];
	logic [CNT_W-1:0]           count_q;
	logic [lrukv_pkg::CFG_W-1:0] cap_q;

	logic          func_q;
	logic [KW-1:0] key_q;
	logic [VW-1:0] val_q;

	logic [IDX_W-1:0] idx_q;
	logic             scan_v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [KW-1:0]    key_rd_s1;
	logic [VW-1:0]    val_rd_s1;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_slot_q;
	logic [RANK_W-1:0] hit_rank_q;
	logic [VW-1:0]     hit_val_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_slot_q;
	logic [IDX_W-1:0]  victim_q;

	logic                       out_valid_q;
	logic [VW-1:0]              out_data_q;
	logic [lrukv_pkg::OUT_USER_W-1:0] out_user_q;

	logic [EW-1:0]     cap_ext;
	logic [EW-1:0]     eff_cap;
	logic              evict;
	logic              insert;
	logic [IDX_W-1:0]  slot;
	logic [CNT_W-1:0]  cnt_m1;
	logic              s1_valid;
	logic [CAPACITY-1:0] valid_d;
	logic [RANK_W-1:0]   rank_d [CAPACITY];
	logic [VW-1:0]     res_data;

	assign cap_ext = EW'(cap_q);
	assign eff_cap = (cap_q == '0) ? EW'(1) :
		((cap_ext > EW'(CAPACITY)) ? EW'(CAPACITY) : cap_ext);
	assign insert  = (func_q == lrukv_pkg::FUNC_PUT) && !hit_q;
	assign evict   = insert && (EW'(count_q) >= eff_cap);
	assign slot    = !evict ? free_slot_q :
		((free_q && (free_slot_q < victim_q)) ? free_slot_q : victim_q);
	assign cnt_m1  = count_q - CNT_W'(1);
	assign s1_valid = valid_q[idx_s1];

	assign status.scan_last = (idx_q == IDX_W'(CAPACITY - 1));
	assign status.out_busy  = out_valid_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lrukv_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q <= s_tuser;
			key_q  <= s_tdata[KW-1:0];
			val_q  <= s_tdata[KW+VW-1:KW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			scan_v_s1 <= 1'b0;
		end else begin
			scan_v_s1 <= cmd.scan;
			if (cmd.start) begin
				idx_q <= '0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			key_rd_s1 <= key_mem[idx_q];
			val_rd_s1 <= val_mem[idx_q];
			idx_s1    <= idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && insert) begin
			key_mem[slot] <= key_q;
		end
		if (cmd.commit && (func_q == lrukv_pkg::FUNC_PUT)) begin
			val_mem[hit_q ? hit_slot_q : slot] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (scan_v_s1) begin
			if (s1_valid && (key_rd_s1 == key_q) && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!s1_valid && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_v_s1) begin
			if (s1_valid && (key_rd_s1 == key_q) && !hit_q) begin
				hit_slot_q <= idx_s1;
				hit_rank_q <= rank_q[idx_s1];
				hit_val_q  <= val_rd_s1;
			end
			if (!s1_valid && !free_q) begin
				free_slot_q <= idx_s1;
			end
			if (s1_valid && (CNT_W'(rank_q[idx_s1]) == cnt_m1)) begin
				victim_q <= idx_s1;
			end
		end
	end

	always_comb begin
		valid_d = valid_q;
		rank_d  = rank_q;
		if (insert) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (evict && (IDX_W'(i) == victim_q)) begin
					valid_d[i] = 1'b0;
				end
			end
			for (int i = 0; i < CAPACITY; i++) begin
				if (valid_d[i]) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end
			valid_d[slot] = 1'b1;
			rank_d[slot]  = '0;
		end else if (hit_q) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (valid_q[i] && (IDX_W'(i) != hit_slot_q) && (rank_q[i] < hit_rank_q)) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end
			rank_d[hit_slot_q] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			valid_q <= valid_d;
			rank_q  <= rank_d;
			if (insert && !evict) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		if (func_q == lrukv_pkg::FUNC_PUT) begin
			res_data = '0;
		end else if (hit_q) begin
			res_data = hit_val_q;
		end else begin
			res_data = '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q <= res_data;
			out_user_q <= {evict, hit_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

>>> hdl/lrukv_chk.sv
module lrukv_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [lrukv_pkg::VAL_W-1:0]         m_tdata,
	input logic [lrukv_pkg::OUT_USER_W-1:0]    m_tuser
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while previous request in flight");

	a_evict_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> !m_tuser[0])
		else $error("eviction reported on a hit");

	a_evict_put_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata == '0))
		else $error("eviction reported with nonzero data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind lru_key_value_cache lrukv_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> test/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
	logic                        found;
	logic [lrukv_pkg::VAL_W-1:0] data;
	logic                        evicted;
} cache_reply_t;

class lru_cache_shadow;
	logic [lrukv_pkg::KEY_W-1:0] slot_key [lrukv_pkg::CAPACITY_DEF];
	logic [lrukv_pkg::VAL_W-1:0] slot_val [lrukv_pkg::CAPACITY_DEF];
	bit                          slot_valid [lrukv_pkg::CAPACITY_DEF];
	int unsigned                 slot_rank [lrukv_pkg::CAPACITY_DEF];
	int unsigned                 held;
	logic [lrukv_pkg::CFG_W-1:0] capacity_reg = lrukv_pkg::CAP_RESET;
	cache_reply_t                replies [$];
	int                          mismatch_count;
	int                          reply_no;

	function void set_capacity(logic [lrukv_pkg::CFG_W-1:0] c);
		capacity_reg = c;
	endfunction

	function int pending();
		return replies.size();
	endfunction

	function void promote(int s);
		for (int i = 0; i < lrukv_pkg::CAPACITY_DEF; i++) begin
			if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s])
				slot_rank[i]++;
		end
		slot_rank[s] = 0;
	endfunction

	function void note_request(logic func, logic [lrukv_pkg::KEY_W-1:0] k,
			logic [lrukv_pkg::VAL_W-1:0] v);
		cache_reply_t r;
		int hit;
		int victim;
		int slot;
		int unsigned lim;
		r.found = 1'b0;
		r.data = '0;
		r.evicted = 1'b0;
		hit = -1;
		for (int i = 0; i < lrukv_pkg::CAPACITY_DEF; i++) begin
			if (hit < 0 && slot_valid[i] && slot_key[i] == k)
				hit = i;
		end
		if (func == lrukv_pkg::FUNC_GET) begin
			if (hit >= 0) begin
				r.found = 1'b1;
				r.data = slot_val[hit];
				promote(hit);
			end else begin
				r.data = '1;
			end
		end else if (hit >= 0) begin
			r.found = 1'b1;
			slot_val[hit] = v;
			promote(hit);
		end else begin
			lim = (capacity_reg == 0) ? 1 : capacity_reg;
			if (lim > lrukv_pkg::CAPACITY_DEF)
				lim = lrukv_pkg::CAPACITY_DEF;
			if (held >= lim && held > 0) begin
				victim = -1;
				for (int i = 0; i < lrukv_pkg::CAPACITY_DEF; i++) begin
					if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
						victim = i;
				end
				if (victim >= 0) begin
					slot_valid[victim] = 1'b0;
					slot_rank[victim] = 0;
					held--;
					r.evicted = 1'b1;
				end
			end
			slot = -1;
			for (int i = 0; i < lrukv_pkg::CAPACITY_DEF; i++) begin
				if (slot < 0 && !slot_valid[i])
					slot = i;
			end
			if (slot >= 0) begin
				for (int i = 0; i < lrukv_pkg::CAPACITY_DEF; i++) begin
					if (slot_valid[i])
						slot_rank[i]++;
				end
				slot_key[slot] = k;
				slot_val[slot] = v;
				slot_valid[slot] = 1'b1;
				slot_rank[slot] = 0;
				held++;
			end
		end
		replies.push_back(r);
	endfunction

	task report_mismatch(string msg);
		$display("reply %0d: %s", reply_no, msg);
		mismatch_count++;
	endtask

	task check_reply(logic fnd, logic [lrukv_pkg::VAL_W-1:0] d, logic ev);
		cache_reply_t want;
		reply_no++;
		if (replies.size() == 0) begin
			report_mismatch("reply with no request outstanding");
			return;
		end
		want = replies.pop_front();
		if (fnd !== want.found)
			report_mismatch($sformatf("found %b, want %b", fnd, want.found));
		if (d !== want.data)
			report_mismatch($sformatf("data %h, want %h", d, want.data));
		if (ev !== want.evicted)
			report_mismatch($sformatf("evicted %b, want %b", ev, want.evicted));
	endtask
endclass

module lru_key_value_cache_tb;
	localparam int CFG_W       = lrukv_pkg::CFG_W;
	localparam int KEY_W       = lrukv_pkg::KEY_W;
	localparam int VAL_W       = lrukv_pkg::VAL_W;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int POOL_SIZE   = 24;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 160;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [CFG_W-1:0]                   cfg_wdata;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [lrukv_pkg::IN_DATA_W-1:0]    s_tdata;
	logic                               s_tuser;
	logic                               m_tvalid;
	logic                               m_tready;
	logic [VAL_W-1:0]                   m_tdata;
	logic [lrukv_pkg::OUT_USER_W-1:0]   m_tuser;

	lru_cache_shadow  model;
	int               send_idle;
	int               recv_stall;
	int               hold_requests;
	int               quiet_cycles;
	int               window;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	lru_key_value_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [KEY_W-1:0] fresh_key();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send(logic f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {v, k};
		s_tuser <= f;
		do @(posedge clk); while (!s_tready);
		model.note_request(f, k, v);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (model.pending() != 0);
	endtask

	task automatic write_capacity(logic [CFG_W-1:0] c);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		model.set_capacity(c);
	endtask

	task automatic rand_request();
		logic             f;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		f = ($urandom_range(99) < 55) ? lrukv_pkg::FUNC_PUT : lrukv_pkg::FUNC_GET;
		if ($urandom_range(9) == 0)
			k = $urandom;
		else
			k = key_pool[$urandom_range(window - 1)];
		if ($urandom_range(15) == 0)
			v = fresh_key();
		else
			v = $urandom;
		send(f, k, v);
	endtask

	// receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			model.check_reply(m_tuser[0], m_tdata, m_tuser[1]);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [CFG_W-1:0] cap;
		model = new();
		quiet_cycles = 0;
		send_idle = 0;
		recv_stall = 0;
		hold_requests = 0;
		window = 2;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = lrukv_pkg::FUNC_GET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single entry: a new key pushes out the one held
		write_capacity(CFG_W'(1));
		send(lrukv_pkg::FUNC_GET, 32'h0000_0000, 32'h5A5A_5A5A);
		send(lrukv_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send(lrukv_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
		send(lrukv_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send(lrukv_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
		send(lrukv_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send(lrukv_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// zero acts as one
		write_capacity(CFG_W'(0));
		send(lrukv_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
		send(lrukv_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		drain();

		// above the slot count saturates
		write_capacity(CFG_W'(31));
		send(lrukv_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0001);
		send(lrukv_pkg::FUNC_PUT, 32'h0000_0001, 32'hFFFF_FFFF);
		send(lrukv_pkg::FUNC_PUT, 32'hFFFF_FFFE, 32'h8000_0000);
		send(lrukv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send(lrukv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
		send(lrukv_pkg::FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
		send(lrukv_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send(lrukv_pkg::FUNC_GET, 32'h0000_0001, 32'hFFFF_FFFF);
		drain();

		// lowered below the count: each new key evicts one, count holds
		write_capacity(CFG_W'(3));
		send(lrukv_pkg::FUNC_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
		send(lrukv_pkg::FUNC_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
		send(lrukv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send(lrukv_pkg::FUNC_GET, 32'h5555_5555, 32'h0000_0000);
		drain();

		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = fresh_key();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: cap = CFG_W'(2);
				1: cap = CFG_W'(4);
				2: cap = CFG_W'(0);
				3: cap = CFG_W'(7);
				4: cap = CFG_W'(16);
				5: cap = CFG_W'(31);
				6: cap = CFG_W'(1);
				7: cap = CFG_W'(17);
				default: cap = CFG_W'($urandom_range(31));
			endcase
			write_capacity(cap);
			case (p % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 79; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 79; end
				default: begin send_idle = 10; recv_stall = 10; end
			endcase
			for (int i = 0; i < POOL_SIZE; i++) begin
				if ($urandom_range(3) == 0)
					key_pool[i] = fresh_key();
			end
			window = $urandom_range(2, POOL_SIZE);
			if (p == 4)
				hold_requests++;
			repeat (PHASE_ITEMS) rand_request();
			drain();
		end

		send_idle = 0;
		recv_stall = 0;
		repeat (40) @(posedge clk);
		if (model.mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
